// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the I2C master bit engine.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every rising edge of clk.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/i2cmbe_pkg.sv
// Types, request codes and the pin-sequence programs of the I2C master bit engine.
// No dependencies; imported by i2c_master_bit_engine.
`default_nettype none

package i2cmbe_pkg;

	// Request codes carried on req_type.
	localparam logic [2:0] REQ_START     = 3'd0;
	localparam logic [2:0] REQ_STOP      = 3'd1;
	localparam logic [2:0] REQ_SEND_BYTE = 3'd2;
	localparam logic [2:0] REQ_RECV_ACK  = 3'd3;
	localparam logic [2:0] REQ_RECV_BYTE = 3'd4;
	localparam logic [2:0] REQ_SEND_ACK  = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SCL_HOLD   = 2'd0;
	localparam logic [1:0] CFG_SDA_HOLD   = 2'd1;
	localparam logic [1:0] CFG_START_HOLD = 2'd2;
	localparam logic [1:0] CFG_STOP_HOLD  = 2'd3;

	localparam logic [7:0] HOLD_RESET = 8'd1;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Branch targets of the two bit loops.
	localparam logic [3:0] LOOP0_TARGET = 4'd0;
	localparam logic [3:0] LOOP3_TARGET = 4'd3;

	// Zero-time steps resolved after a tick: an empty wait, a loop test, the end.
	localparam int SETTLE_STEPS = 3;

	typedef enum logic [4:0] {
		OP_END    = 5'd0,
		OP_SCL0   = 5'd1,
		OP_SCL1   = 5'd2,
		OP_SDA0   = 5'd3,
		OP_SDA1   = 5'd4,
		OP_SDABIT = 5'd5,
		OP_SDAACK = 5'd6,
		OP_REL    = 5'd7,
		OP_DRIVE  = 5'd8,
		OP_SMPACK = 5'd9,
		OP_SMPBIT = 5'd10,
		OP_WSCL   = 5'd11,
		OP_WSDA   = 5'd12,
		OP_WSTA   = 5'd13,
		OP_WSTO   = 5'd14,
		OP_LOOP0  = 5'd15,
		OP_LOOP3  = 5'd16
	} op_t;

	typedef struct packed {
		logic [7:0] scl_hold;
		logic [7:0] sda_hold;
		logic [7:0] start_hold;
		logic [7:0] stop_hold;
	} cfg_t;

	typedef struct packed {
		logic       busy;
		logic [3:0] pc;
		logic [2:0] cmd;
		logic [3:0] bitc;
		logic [7:0] waitc;
		logic [7:0] shift;
		logic       ackl;
		logic       scl;
		logic       sda;
		logic       en;
		logic [7:0] rxb;
		logic       ackr;
		logic       done;
	} seq_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drive;
		logic       busy;
		logic       done;
		logic [7:0] rxb;
		logic       ack;
	} res_t;

	// Micro-program of each request; positions past the end read as OP_END.
	function automatic op_t prog_op(logic [2:0] cmd, logic [3:0] pc);
		op_t op;
		op = OP_END;
		case (cmd)
			REQ_START: begin
				case (pc)
					4'd0: op = OP_SCL0;
					4'd1: op = OP_SDA1;
					4'd2: op = OP_SCL1;
					4'd3: op = OP_WSCL;
					4'd4: op = OP_SDA0;
					4'd5: op = OP_WSTA;
					default: op = OP_END;
				endcase
			end
			REQ_STOP: begin
				case (pc)
					4'd0: op = OP_SCL0;
					4'd1: op = OP_SDA0;
					4'd2: op = OP_SCL1;
					4'd3: op = OP_WSCL;
					4'd4: op = OP_SDA1;
					4'd5: op = OP_WSTO;
					default: op = OP_END;
				endcase
			end
			REQ_SEND_BYTE: begin
				case (pc)
					4'd0: op = OP_SCL0;
					4'd1: op = OP_WSCL;
					4'd2: op = OP_SDABIT;
					4'd3: op = OP_SCL1;
					4'd4: op = OP_WSDA;
					4'd5: op = OP_LOOP0;
					4'd6: op = OP_SCL0;
					4'd7: op = OP_REL;
					default: op = OP_END;
				endcase
			end
			REQ_RECV_ACK: begin
				case (pc)
					4'd0: op = OP_WSCL;
					4'd1: op = OP_SCL1;
					4'd2: op = OP_WSDA;
					4'd3: op = OP_SMPACK;
					4'd4: op = OP_DRIVE;
					default: op = OP_END;
				endcase
			end
			REQ_RECV_BYTE: begin
				case (pc)
					4'd0: op = OP_SCL0;
					4'd1: op = OP_REL;
					4'd2: op = OP_WSCL;
					4'd3: op = OP_SCL1;
					4'd4: op = OP_WSDA;
					4'd5: op = OP_SMPBIT;
					4'd6: op = OP_WSCL;
					4'd7: op = OP_LOOP3;
					4'd8: op = OP_DRIVE;
					default: op = OP_END;
				endcase
			end
			REQ_SEND_ACK: begin
				case (pc)
					4'd0: op = OP_SCL0;
					4'd1: op = OP_WSCL;
					4'd2: op = OP_SDAACK;
					4'd3: op = OP_WSDA;
					4'd4: op = OP_SCL1;
					default: op = OP_END;
				endcase
			end
			default: op = OP_END;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

// File: rtl/i2c_master_bit_engine.sv
// I2C master bit engine: one request is one clock tick of the pin sequencer.
// A request is held in the input register; its result is in the output register after
// the next edge at which that register is free.
// Throughput: one request per cycle while the result side keeps taking results.
// Reset (arst_n low): SCL and SDA high and driven, sequencer idle, hold registers at 1.
// Depends on i2cmbe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2c_master_bit_engine (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write_en,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       cmd_valid,
	input  wire logic [2:0] req_type,
	input  wire logic [7:0] tx_byte,
	input  wire logic       ack_to_send,
	input  wire logic       sda_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            scl_out,
	output logic            sda_out,
	output logic            sda_drive,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      rx_byte,
	output logic            ack_seen
);
	import i2cmbe_pkg::*;

	cfg_t cfg_q;
	seq_t seq_q;
	seq_t seq_cur;
	seq_t seq_nx;
	res_t res_q;
	logic out_valid_q;

	logic       valid_s1;
	logic       cmd_valid_s1;
	logic [2:0] req_type_s1;
	logic [7:0] tx_byte_s1;
	logic       ack_to_send_s1;
	logic       sda_in_s1;
	logic       fire;

	// Load the hold counter when the sequencer lands on a wait.
	function automatic seq_t enter_op(seq_t s, cfg_t cfg);
		seq_t r;
		r = s;
		case (prog_op(s.cmd, s.pc))
			OP_WSCL: r.waitc = cfg.scl_hold;
			OP_WSDA: r.waitc = cfg.sda_hold;
			OP_WSTA: r.waitc = cfg.start_hold;
			OP_WSTO: r.waitc = cfg.stop_hold;
			default: r.waitc = s.waitc;
		endcase
		return r;
	endfunction

	function automatic seq_t advance(seq_t s, cfg_t cfg);
		seq_t r;
		r = s;
		r.pc = s.pc + 4'd1;
		return enter_op(r, cfg);
	endfunction

	// Resolve the steps that take no tick: empty waits, loop tests and the end.
	function automatic seq_t settle(seq_t s, cfg_t cfg);
		seq_t r;
		logic halt;
		op_t  op;
		r = s;
		halt = 1'b0;
		for (int i = 0; i < SETTLE_STEPS; i++) begin
			op = prog_op(r.cmd, r.pc);
			if (r.busy && !halt) begin
				case (op)
					OP_WSCL, OP_WSDA, OP_WSTA, OP_WSTO: begin
						if (r.waitc == 8'd0) begin
							r = advance(r, cfg);
						end else begin
							halt = 1'b1;
						end
					end
					OP_LOOP0, OP_LOOP3: begin
						r.bitc = r.bitc + 4'd1;
						if (r.bitc < BITS_PER_BYTE) begin
							r.pc = (op == OP_LOOP0) ? LOOP0_TARGET : LOOP3_TARGET;
							r = enter_op(r, cfg);
						end else begin
							r = advance(r, cfg);
						end
					end
					OP_END: begin
						r.busy = 1'b0;
						r.done = 1'b1;
					end
					default: halt = 1'b1;
				endcase
			end
		end
		return r;
	endfunction

	// Perform the one pin action or wait tick at the current position.
	function automatic seq_t tick(seq_t s, cfg_t cfg, logic pin);
		seq_t r;
		logic adv;
		r = s;
		adv = 1'b1;
		case (prog_op(s.cmd, s.pc))
			OP_WSCL, OP_WSDA, OP_WSTA, OP_WSTO: begin
				r.waitc = s.waitc - 8'd1;
				adv = (r.waitc == 8'd0);
			end
			OP_SCL0: r.scl = 1'b0;
			OP_SCL1: r.scl = 1'b1;
			OP_SDA0: r.sda = 1'b0;
			OP_SDA1: r.sda = 1'b1;
			OP_SDABIT: begin
				r.sda = s.shift[7];
				r.shift = {s.shift[6:0], 1'b0};
			end
			OP_SDAACK: r.sda = s.ackl;
			OP_REL: r.en = 1'b0;
			OP_DRIVE: begin
				r.en = 1'b1;
				if (s.cmd == REQ_RECV_BYTE) begin
					r.rxb = s.shift;
				end
			end
			OP_SMPACK: begin
				r.ackr = pin;
				r.scl = 1'b0;
			end
			OP_SMPBIT: begin
				r.shift = {s.shift[6:0], pin};
				r.scl = 1'b0;
			end
			default: adv = 1'b1;
		endcase
		if (adv) begin
			r = advance(r, cfg);
		end
		return r;
	endfunction

	assign fire = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{scl_hold: HOLD_RESET, sda_hold: HOLD_RESET,
				start_hold: HOLD_RESET, stop_hold: HOLD_RESET};
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_SCL_HOLD:   cfg_q.scl_hold <= cfg_data;
				CFG_SDA_HOLD:   cfg_q.sda_hold <= cfg_data;
				CFG_START_HOLD: cfg_q.start_hold <= cfg_data;
				CFG_STOP_HOLD:  cfg_q.stop_hold <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_valid_s1 <= cmd_valid;
			req_type_s1 <= req_type;
			tx_byte_s1 <= tx_byte;
			ack_to_send_s1 <= ack_to_send;
			sda_in_s1 <= sda_in;
		end
	end

	// A request offered while busy is dropped; an unknown code leaves the block idle.
	always_comb begin
		seq_cur = seq_q;
		seq_cur.done = 1'b0;
		seq_nx = seq_cur;
		if (!seq_cur.busy) begin
			if (cmd_valid_s1 && req_type_s1 <= REQ_SEND_ACK) begin
				seq_nx.cmd = req_type_s1;
				seq_nx.bitc = 4'd0;
				seq_nx.waitc = 8'd0;
				seq_nx.shift = (req_type_s1 == REQ_SEND_BYTE) ? tx_byte_s1 : 8'd0;
				seq_nx.ackl = ack_to_send_s1;
				seq_nx.pc = 4'd0;
				seq_nx.busy = 1'b1;
				seq_nx = settle(enter_op(seq_nx, cfg_q), cfg_q);
				if (seq_nx.busy) begin
					seq_nx = settle(tick(seq_nx, cfg_q, sda_in_s1), cfg_q);
				end
			end
		end else begin
			seq_nx = settle(tick(seq_cur, cfg_q, sda_in_s1), cfg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '{busy: 1'b0, pc: 4'd0, cmd: 3'd0, bitc: 4'd0, waitc: 8'd0,
				shift: 8'd0, ackl: 1'b0, scl: 1'b1, sda: 1'b1, en: 1'b1,
				rxb: 8'd0, ackr: 1'b0, done: 1'b0};
			res_q <= '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b0, done: 1'b0,
				rxb: 8'd0, ack: 1'b0};
			out_valid_q <= 1'b0;
		end else if (fire) begin
			seq_q <= seq_nx;
			res_q <= '{scl: seq_nx.scl, sda: seq_nx.sda, drive: seq_nx.en,
				busy: seq_nx.busy, done: seq_nx.done, rxb: seq_nx.rxb, ack: seq_nx.ackr};
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_out = res_q.scl;
	assign sda_out = res_q.sda;
	assign sda_drive = res_q.drive;
	assign busy_res = res_q.busy;
	assign done_res = res_q.done;
	assign rx_byte = res_q.rxb;
	assign ack_seen = res_q.ack;

	`ASSERT_CLK(a_done_idle, !res_q.done || !seq_q.busy, "done reported while still busy")
	`ASSERT_CLK(a_bitc_range, seq_q.bitc <= BITS_PER_BYTE, "bit counter past one byte")
	`ASSERT_CLK(a_send_release, !(res_q.done && seq_q.cmd == REQ_SEND_BYTE) || !res_q.drive,
		"send byte finished with SDA still driven")
	`ASSERT_NEXT(a_hold_state, !fire, $stable(seq_q), "sequencer moved without a request")

endmodule

`default_nettype wire

// File: test/tb_i2c_master_bit_engine.sv
`timescale 1ns / 100ps
// Testbench for i2c_master_bit_engine: drives pin-sequencer ticks with random idling and
// checks every result against a tick-by-tick model of the SCL/SDA command sequences.
// Depends on i2cmbe_pkg and the i2c_master_bit_engine RTL.

module tb_i2c_master_bit_engine;
	import i2cmbe_pkg::*;

	localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
	localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
	localparam int LONG_HOLD_CYCLES = 60;

	// One request is one tick of the sequencer.
	typedef struct packed {
		logic       go;
		logic [2:0] req;
		logic [7:0] tx;
		logic       ack;
		logic       sda;
	} tick_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write_en = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       cmd_valid = 1'b0;
	logic [2:0] req_type = '0;
	logic [7:0] tx_byte = '0;
	logic       ack_to_send = 1'b0;
	logic       sda_in = 1'b1;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       scl_out;
	logic       sda_out;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	// Sequencer model state and its copy of the hold registers.
	logic [7:0] hold_scl, hold_sda, hold_start, hold_stop;
	logic [4:0] seq_phase;
	logic [2:0] seq_cmd;
	logic [3:0] seq_bits;
	logic [7:0] seq_wait, seq_shift;
	logic       seq_ack_lvl, pin_scl, pin_sda, pin_en, ack_last, done_now;
	logic [7:0] rx_last;

	res_t pin_expect_q[$];
	int   mismatch_count = 0;
	int   send_gap_rate = 3;
	int   sink_stall_rate = 3;
	logic long_hold_req = 1'b0;

	i2c_master_bit_engine dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd_valid(cmd_valid), .req_type(req_type), .tx_byte(tx_byte),
		.ack_to_send(ack_to_send), .sda_in(sda_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.scl_out(scl_out), .sda_out(sda_out), .sda_drive(sda_drive),
		.busy_res(busy_res), .done_res(done_res), .rx_byte(rx_byte), .ack_seen(ack_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#(20_000_000);
		$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------- sequencer model

	function automatic op_t program_op(logic [2:0] cmd, logic [4:0] ph);
		op_t ops [0:9];
		ops = '{default: OP_END};
		case (cmd)
			REQ_START: ops = '{OP_SCL0, OP_SDA1, OP_SCL1, OP_WSCL, OP_SDA0, OP_WSTA,
				OP_END, OP_END, OP_END, OP_END};
			REQ_STOP: ops = '{OP_SCL0, OP_SDA0, OP_SCL1, OP_WSCL, OP_SDA1, OP_WSTO,
				OP_END, OP_END, OP_END, OP_END};
			REQ_SEND_BYTE: ops = '{OP_SCL0, OP_WSCL, OP_SDABIT, OP_SCL1, OP_WSDA, OP_LOOP0,
				OP_SCL0, OP_REL, OP_END, OP_END};
			REQ_RECV_ACK: ops = '{OP_WSCL, OP_SCL1, OP_WSDA, OP_SMPACK, OP_DRIVE,
				OP_END, OP_END, OP_END, OP_END, OP_END};
			REQ_RECV_BYTE: ops = '{OP_SCL0, OP_REL, OP_WSCL, OP_SCL1, OP_WSDA, OP_SMPBIT,
				OP_WSCL, OP_LOOP3, OP_DRIVE, OP_END};
			REQ_SEND_ACK: ops = '{OP_SCL0, OP_WSCL, OP_SDAACK, OP_WSDA, OP_SCL1,
				OP_END, OP_END, OP_END, OP_END, OP_END};
			default: ;
		endcase
		if (ph == 5'd0 || ph > 5'd10)
			return OP_END;
		return ops[ph - 5'd1];
	endfunction

	function automatic logic is_wait(op_t op);
		return op == OP_WSCL || op == OP_WSDA || op == OP_WSTA || op == OP_WSTO;
	endfunction

	task automatic load_wait();
		case (program_op(seq_cmd, seq_phase))
			OP_WSCL: seq_wait = hold_scl;
			OP_WSDA: seq_wait = hold_sda;
			OP_WSTA: seq_wait = hold_start;
			OP_WSTO: seq_wait = hold_stop;
			default: ;
		endcase
	endtask

	task automatic goto_pc(logic [3:0] pc);
		seq_phase = {1'b0, pc} + 5'd1;
		load_wait();
	endtask

	task automatic step_phase();
		seq_phase = seq_phase + 5'd1;
		load_wait();
	endtask

	// Empty waits, loop tests and the end of a program take no tick.
	task automatic settle_zero_time();
		op_t op;
		int  guard;
		for (guard = 0; guard < 64 && seq_phase != 5'd0; guard++) begin
			op = program_op(seq_cmd, seq_phase);
			if (is_wait(op) && seq_wait == 8'd0) begin
				step_phase();
			end else if (op == OP_LOOP0 || op == OP_LOOP3) begin
				seq_bits = seq_bits + 4'd1;
				if (seq_bits < BITS_PER_BYTE)
					goto_pc(op == OP_LOOP0 ? LOOP0_TARGET : LOOP3_TARGET);
				else
					step_phase();
			end else if (op == OP_END) begin
				seq_phase = 5'd0;
				done_now = 1'b1;
			end else begin
				break;
			end
		end
	endtask

	task automatic tick_pins(logic sda_pin);
		op_t op;
		op = program_op(seq_cmd, seq_phase);
		if (is_wait(op)) begin
			seq_wait = seq_wait - 8'd1;
			if (seq_wait == 8'd0)
				step_phase();
		end else begin
			case (op)
				OP_SCL0: pin_scl = 1'b0;
				OP_SCL1: pin_scl = 1'b1;
				OP_SDA0: pin_sda = 1'b0;
				OP_SDA1: pin_sda = 1'b1;
				OP_SDABIT: begin
					pin_sda = seq_shift[7];
					seq_shift = {seq_shift[6:0], 1'b0};
				end
				OP_SDAACK: pin_sda = seq_ack_lvl;
				OP_REL: pin_en = 1'b0;
				OP_DRIVE: begin
					pin_en = 1'b1;
					if (seq_cmd == REQ_RECV_BYTE)
						rx_last = seq_shift;
				end
				OP_SMPACK: begin
					ack_last = sda_pin;
					pin_scl = 1'b0;
				end
				OP_SMPBIT: begin
					seq_shift = {seq_shift[6:0], sda_pin};
					pin_scl = 1'b0;
				end
				default: ;
			endcase
			step_phase();
		end
	endtask

	task automatic reset_pin_model();
		hold_scl = HOLD_RESET;
		hold_sda = HOLD_RESET;
		hold_start = HOLD_RESET;
		hold_stop = HOLD_RESET;
		seq_phase = '0;
		seq_cmd = '0;
		seq_bits = '0;
		seq_wait = '0;
		seq_shift = '0;
		seq_ack_lvl = 1'b0;
		pin_scl = 1'b1;
		pin_sda = 1'b1;
		pin_en = 1'b1;
		rx_last = '0;
		ack_last = 1'b0;
		done_now = 1'b0;
	endtask

	task automatic predict_pins(input tick_t t, output res_t r);
		done_now = 1'b0;
		if (seq_phase == 5'd0) begin
			// Unknown codes and requests without go leave the sequencer idle.
			if (t.go && t.req <= REQ_SEND_ACK) begin
				seq_cmd = t.req;
				seq_bits = '0;
				seq_wait = '0;
				seq_shift = (t.req == REQ_SEND_BYTE) ? t.tx : 8'h00;
				seq_ack_lvl = t.ack;
				goto_pc(4'd0);
				settle_zero_time();
				if (seq_phase != 5'd0) begin
					tick_pins(t.sda);
					settle_zero_time();
				end
			end
		end else begin
			tick_pins(t.sda);
			settle_zero_time();
		end
		r.scl = pin_scl;
		r.sda = pin_sda;
		r.drive = pin_en;
		r.busy = (seq_phase != 5'd0);
		r.done = done_now;
		r.rxb = rx_last;
		r.ack = ack_last;
	endtask

	// ---------------------------------------------------------------- result checking

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch on %s at %0t: expected %h, got %h", name, $realtime, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pin_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result at %0t with no request pending", $realtime);
			end else begin
				want = pin_expect_q.pop_front();
				check_field("scl_out", 8'(want.scl), 8'(scl_out));
				check_field("sda_out", 8'(want.sda), 8'(sda_out));
				check_field("sda_drive", 8'(want.drive), 8'(sda_drive));
				check_field("busy_res", 8'(want.busy), 8'(busy_res));
				check_field("done_res", 8'(want.done), 8'(done_res));
				check_field("rx_byte", want.rxb, rx_byte);
				check_field("ack_seen", 8'(want.ack), 8'(ack_seen));
			end
		end
	end

	initial begin : result_sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (sink_stall_rate != 0 && $urandom_range(0, 15) < sink_stall_rate) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic send_tick(input tick_t t);
		res_t r;
		in_valid <= 1'b1;
		cmd_valid <= t.go;
		req_type <= t.req;
		tx_byte <= t.tx;
		ack_to_send <= t.ack;
		sda_in <= t.sda;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_pins(t, r);
		pin_expect_q.push_back(r);
		if (send_gap_rate != 0 && $urandom_range(0, 15) < send_gap_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic stop_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// sda_pin 0 or 1 holds the SDA pin at that level; any other value randomizes it.
	function automatic tick_t busy_noise(int sda_pin);
		tick_t t;
		t.go = 1'($urandom_range(0, 1));
		t.req = 3'($urandom_range(0, 7));
		t.tx = 8'($urandom_range(0, 255));
		t.ack = 1'($urandom_range(0, 1));
		t.sda = (sda_pin == 0 || sda_pin == 1) ? sda_pin[0] : 1'($urandom_range(0, 1));
		return t;
	endfunction

	// Requests offered while a command runs carry random commands that must be ignored.
	task automatic finish_busy(int sda_pin);
		while (seq_phase != 5'd0)
			send_tick(busy_noise(sda_pin));
	endtask

	task automatic run_request(logic [2:0] req, logic [7:0] tx, logic ack, int sda_pin);
		tick_t t;
		t = busy_noise(sda_pin);
		t.go = 1'b1;
		t.req = req;
		t.tx = tx;
		t.ack = ack;
		send_tick(t);
		finish_busy(sda_pin);
	endtask

	task automatic run_every_request();
		run_request(REQ_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2);
		run_request(REQ_SEND_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2);
		run_request(REQ_RECV_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2);
		run_request(REQ_RECV_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2);
		run_request(REQ_SEND_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2);
		run_request(REQ_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2);
	endtask

	// Waits until the sequencer is idle and every result has come back.
	task automatic settle_block();
		finish_busy(2);
		stop_input();
		while (pin_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_holds(logic [7:0] scl_h, logic [7:0] sda_h, logic [7:0] sta_h,
		logic [7:0] sto_h);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_SCL_HOLD;
		cfg_data <= scl_h;
		@(posedge clk);
		cfg_index <= CFG_SDA_HOLD;
		cfg_data <= sda_h;
		@(posedge clk);
		cfg_index <= CFG_START_HOLD;
		cfg_data <= sta_h;
		@(posedge clk);
		cfg_index <= CFG_STOP_HOLD;
		cfg_data <= sto_h;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		hold_scl = scl_h;
		hold_sda = sda_h;
		hold_start = sta_h;
		hold_stop = sto_h;
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_each_request();
		tick_t t;
		run_request(REQ_START, 8'h00, 1'b0, 2);
		run_request(REQ_SEND_BYTE, 8'hA5, 1'b1, 2);
		// SDA is still released here; start must leave the enable alone.
		run_request(REQ_START, 8'h5A, 1'b1, 2);
		run_request(REQ_RECV_ACK, 8'hFF, 1'b1, 0);
		run_request(REQ_RECV_ACK, 8'h00, 1'b0, 1);
		run_request(REQ_SEND_ACK, 8'hFF, 1'b0, 2);
		run_request(REQ_SEND_ACK, 8'h00, 1'b1, 2);
		run_request(REQ_STOP, 8'h81, 1'b1, 2);
		t = '{1'b1, REQ_UNKNOWN_LO, 8'hFF, 1'b1, 1'b1};
		send_tick(t);
		t = '{1'b1, REQ_UNKNOWN_HI, 8'h00, 1'b0, 1'b0};
		send_tick(t);
		t = '{1'b0, REQ_SEND_BYTE, 8'hC3, 1'b1, 1'b0};
		send_tick(t);
		run_request(REQ_STOP, 8'h00, 1'b0, 2);
	endtask

	task automatic test_zero_holds();
		settle_block();
		load_holds(8'd0, 8'd0, 8'd0, 8'd0);
		run_every_request();
	endtask

	// The largest hold value runs to completion on a stop condition.
	task automatic test_max_holds();
		settle_block();
		load_holds(8'd0, 8'd0, 8'd0, 8'd255);
		run_request(REQ_STOP, 8'h00, 1'b0, 2);
	endtask

	// The sink holds off long enough that the block fills and stalls its input.
	task automatic test_backpressure();
		settle_block();
		load_holds(8'd2, 8'd1, 8'd3, 8'd0);
		send_gap_rate = 0;
		long_hold_req = 1'b1;
		run_request(REQ_SEND_BYTE, 8'($urandom_range(0, 255)), 1'b0, 2);
		send_gap_rate = 3;
	endtask

	task automatic test_unstalled_finish();
		settle_block();
		send_gap_rate = 0;
		sink_stall_rate = 0;
		load_holds(8'd1, 8'd0, 8'd1, 8'd0);
		run_every_request();
	endtask

	initial begin
		reset_pin_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_each_request();
		test_zero_holds();
		test_max_holds();
		test_backpressure();
		test_unstalled_finish();
		stop_input();
		while (pin_expect_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
